### src/scpm_pkg.sv
// Shared types and constants of the segment cut profile block
package scpm_pkg;

  // Request kinds
  localparam logic [1:0] KIND_CUT   = 2'd0;
  localparam logic [1:0] KIND_RESET = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] REG_WORK_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS  = 1'b1;
  localparam logic [10:0] WORK_LENGTH_RST = 11'd1024;
  localparam logic [14:0] MAX_RADIUS_RST  = 15'd1024;

  // Divider and slope accumulator widths
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 16;
  localparam int QW     = 18;

  typedef enum logic [3:0] {
    ST_BOOT_FILL,
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIVQ,
    ST_DIVQ_WAIT,
    ST_DIVO,
    ST_DIVO_WAIT,
    ST_WALK,
    ST_DRAIN,
    ST_FILL,
    ST_RD,
    ST_RD_WAIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul;
    logic div_start;
    logic div_off;
    logic take_step;
    logic take_off;
    logic step;
    logic fill;
    logic boot;
    logic rd_issue;
    logic rd_take;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       empty;
    logic       vertical;
    logic       rd_ok;
    logic       div_done;
    logic       walk_last;
    logic       fill_last;
    logic       out_free;
  } status_t;

endpackage

### src/scpm_in_if.sv
// Request channel: valid/ready handshake with the cut, reset or read fields
interface scpm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] x_first;
  logic signed [15:0] y_first;
  logic signed [15:0] x_second;
  logic signed [15:0] y_second;

  modport source (output valid, kind, x_first, y_first, x_second, y_second, input ready);
  modport sink   (input valid, kind, x_first, y_first, x_second, y_second, output ready);
endinterface

### src/scpm_out_if.sv
// Result channel: valid/ready handshake with column radius and read flag
interface scpm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] column_radius;
  logic               read_valid;

  modport source (output valid, column_radius, read_valid, input ready);
  modport sink   (input valid, column_radius, read_valid, output ready);
endinterface

### src/scpm_ram.sv
// Generic single-write, single-read RAM with registered read data
module scpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

### src/scpm_div.sv
// Restoring divider, one quotient bit per cycle
module scpm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [scpm_pkg::DIV_NW-1:0] num,
  input  logic [scpm_pkg::DIV_DW-1:0] den,
  output logic                        done,
  output logic [scpm_pkg::DIV_NW-1:0] quo,
  output logic [scpm_pkg::DIV_DW-1:0] rem
);
  localparam int NW = scpm_pkg::DIV_NW;
  localparam int DW = scpm_pkg::DIV_DW;
  localparam int CW = $clog2(NW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, quo_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without a running division");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
endmodule

### src/scpm_dp.sv
// Datapath: configuration, segment set-up, slope walk, profile memory, result register
module scpm_dp #(
  parameter int COLUMNS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  scpm_pkg::cmd_t                       cmd,
  output scpm_pkg::status_t                    status,
  input  logic [1:0]                           in_kind,
  input  logic signed [15:0]                   in_x_first,
  input  logic signed [15:0]                   in_y_first,
  input  logic signed [15:0]                   in_x_second,
  input  logic signed [15:0]                   in_y_second,
  input  logic                                 cfg_we,
  input  logic [scpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scpm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [15:0]                   out_column_radius,
  output logic                                 out_read_valid
);
  localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int QW = scpm_pkg::QW;
  localparam logic [16:0] COLS_W = 17'(COLUMNS);

  // configuration
  logic [10:0] work_length_r;
  logic [14:0] max_radius_r;

  // request
  logic [1:0]         kind_r;
  logic signed [15:0] x1_r, y1_r, x2_r, y2_r;

  // segment set-up
  logic signed [15:0] ys_r;
  logic [15:0]        dx_r;
  logic signed [16:0] dy_r;
  logic [16:0]        k0_r;
  logic signed [34:0] prod_r;
  logic [AW-1:0]      x_r, hi_r;

  // slope walk: height = q + r/dx with 0 <= r < dx
  logic signed [QW-1:0] q_r, qs_r;
  logic [15:0]          r_r, rs_r;

  // memory write-back stage
  logic                 wr_pend_r;
  logic [AW-1:0]        wr_addr_r;
  logic signed [15:0]   h_pipe_r;
  logic [AW-1:0]        fill_cnt_r;

  // result
  logic signed [15:0] res_radius_r;
  logic               res_valid_r;
  logic               out_valid_r;
  logic signed [15:0] out_radius_r;
  logic               out_rv_r;

  // set-up logic
  logic               swap;
  logic signed [15:0] xs, ys, xe, ye, vmin;
  logic signed [16:0] dx17, dy17;
  logic [16:0]        used_w;
  logic signed [17:0] lo18, hi_a, used_m1, hi18;
  logic               empty_w, rd_ok_w;
  logic [16:0]        k0_w;

  // divider hookup
  logic                        div_done;
  logic [scpm_pkg::DIV_NW-1:0] div_num, div_quo;
  logic [scpm_pkg::DIV_DW-1:0] div_rem;
  logic signed [34:0]          prod_mag;
  logic [16:0]                 dy_mag;
  logic                        neg;
  logic signed [QW-1:0]        qm, fq;
  logic [15:0]                 fr;

  // walk logic
  logic [16:0]          rsum, rwrap;
  logic                 wrap;
  logic signed [QW-1:0] q_nxt, h;

  // memory ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  assign used_w = ({6'd0, work_length_r} < COLS_W) ? {6'd0, work_length_r} : COLS_W;

  assign swap  = x2_r < x1_r;
  assign xs    = swap ? x2_r : x1_r;
  assign ys    = swap ? y2_r : y1_r;
  assign xe    = swap ? x1_r : x2_r;
  assign ye    = swap ? y1_r : y2_r;
  assign vmin  = (y1_r < y2_r) ? y1_r : y2_r;
  assign dx17  = {xe[15], xe} - {xs[15], xs};
  assign dy17  = {ye[15], ye} - {ys[15], ys};

  assign lo18    = xs[15] ? 18'sd0 : {{2{xs[15]}}, xs};
  assign hi_a    = {{2{xe[15]}}, xe};
  assign used_m1 = $signed({1'b0, used_w}) - 18'sd1;
  assign hi18    = (hi_a < used_m1) ? hi_a : used_m1;
  assign empty_w = lo18 > hi18;
  assign rd_ok_w = !x1_r[15] && ({{2{x1_r[15]}}, x1_r} < $signed({1'b0, used_w}));
  assign k0_w    = xs[15] ? (17'd0 - {xs[15], xs}) : 17'd0;

  // divide |dy| by dx for the per-column step, or |dy*k0| by dx for the start offset
  assign prod_mag = prod_r[34] ? (35'sd0 - prod_r) : prod_r;
  assign dy_mag   = dy_r[16] ? 17'(-dy_r) : 17'(dy_r);
  assign div_num  = cmd.div_off ? prod_mag[31:0] : {15'd0, dy_mag};
  assign neg      = cmd.div_off ? prod_r[34] : dy_r[16];

  // turn the magnitude quotient into a floor quotient with non-negative remainder
  assign qm = $signed({1'b0, div_quo[QW-2:0]});
  always_comb begin
    if (!neg) begin
      fq = qm;
      fr = div_rem;
    end else if (div_rem == '0) begin
      fq = -qm;
      fr = '0;
    end else begin
      fq = -qm - QW'(1);
      fr = dx_r - div_rem;
    end
  end

  assign rsum  = {1'b0, r_r} + {1'b0, rs_r};
  assign wrap  = rsum >= {1'b0, dx_r};
  assign rwrap = rsum - {1'b0, dx_r};
  assign q_nxt = q_r + qs_r + $signed({{(QW-1){1'b0}}, wrap});
  // toward-zero rounding differs from floor only for a negative value with a fraction
  assign h     = (q_r[QW-1] && (r_r != '0)) ? (q_r + QW'(1)) : q_r;

  scpm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (dx_r),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_length_r <= scpm_pkg::WORK_LENGTH_RST;
      max_radius_r  <= scpm_pkg::MAX_RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        scpm_pkg::REG_WORK_LENGTH: work_length_r <= cfg_wdata[10:0];
        scpm_pkg::REG_MAX_RADIUS:  max_radius_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      x1_r   <= in_x_first;
      y1_r   <= in_y_first;
      x2_r   <= in_x_second;
      y2_r   <= in_y_second;
    end
    if (cmd.prep) begin
      ys_r    <= ys;
      dx_r    <= dx17[15:0];
      dy_r    <= dy17;
      k0_r    <= k0_w;
      x_r     <= lo18[AW-1:0];
      hi_r    <= hi18[AW-1:0];
      // a vertical cut walks one column at the lower end height
      q_r     <= {{(QW-16){vmin[15]}}, vmin};
      r_r     <= '0;
    end
    if (cmd.mul) begin
      prod_r <= dy_r * $signed({1'b0, k0_r});
    end
    if (cmd.take_step) begin
      qs_r <= fq;
      rs_r <= fr;
    end
    if (cmd.take_off) begin
      q_r <= {{(QW-16){ys_r[15]}}, ys_r} + fq;
      r_r <= fr;
    end
    if (cmd.step) begin
      x_r       <= x_r + 1'b1;
      q_r       <= q_nxt;
      r_r       <= wrap ? rwrap[15:0] : rsum[15:0];
      wr_addr_r <= x_r;
      h_pipe_r  <= h[15:0];
    end
    if (cmd.load) begin
      res_radius_r <= '0;
      res_valid_r  <= 1'b0;
    end else if (cmd.rd_take) begin
      res_radius_r <= $signed(ram_rdata);
      res_valid_r  <= 1'b1;
    end
    if (cmd.push) begin
      out_radius_r <= res_radius_r;
      out_rv_r     <= res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r   <= 1'b0;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_pend_r  <= cmd.step;
      fill_cnt_r <= cmd.fill ? (fill_cnt_r + 1'b1) : '0;
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // read column x while the minimum for the previous column is written back;
  // the fill after reset always loads the reset radius
  assign ram_we    = cmd.fill || (wr_pend_r && ($signed(ram_rdata) > h_pipe_r));
  assign ram_waddr = cmd.fill ? fill_cnt_r : wr_addr_r;
  assign ram_wdata = !cmd.fill ? h_pipe_r :
                     cmd.boot  ? {1'b0, scpm_pkg::MAX_RADIUS_RST} : {1'b0, max_radius_r};
  assign ram_re    = cmd.step || cmd.rd_issue;
  assign ram_raddr = cmd.rd_issue ? x1_r[AW-1:0] : x_r;

  scpm_ram #(
    .WIDTH (16),
    .DEPTH (COLUMNS)
  ) u_profile (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // span and read checks come straight from the held request
  assign status.kind      = kind_r;
  assign status.empty     = empty_w;
  assign status.vertical  = (x1_r == x2_r);
  assign status.rd_ok     = rd_ok_w;
  assign status.div_done  = div_done;
  assign status.walk_last = (x_r == hi_r);
  assign status.fill_last = (fill_cnt_r == AW'(COLUMNS - 1));
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_column_radius = out_radius_r;
  assign out_read_valid    = out_rv_r;

  a_walk_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (x_r <= hi_r)) else $error("walk stepped past the last column");
  a_fill_no_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.fill && wr_pend_r)) else $error("fill collided with a pending write-back");
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_ready)) else $error("result overwrote an untaken result");
endmodule

### src/scpm_ctrl.sv
// Controller: sequences set-up, divisions, column walk, fill and result hand-off
module scpm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scpm_pkg::status_t status,
  output scpm_pkg::cmd_t    cmd
);
  scpm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scpm_pkg::ST_BOOT_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scpm_pkg::ST_BOOT_FILL: if (status.fill_last) state_nxt = scpm_pkg::ST_IDLE;
      scpm_pkg::ST_IDLE:      if (in_valid) state_nxt = scpm_pkg::ST_PREP;
      scpm_pkg::ST_PREP: begin
        case (status.kind)
          scpm_pkg::KIND_CUT: begin
            if (status.empty) begin
              state_nxt = scpm_pkg::ST_RESULT;
            end else if (status.vertical) begin
              state_nxt = scpm_pkg::ST_WALK;
            end else begin
              state_nxt = scpm_pkg::ST_MUL;
            end
          end
          scpm_pkg::KIND_RESET: state_nxt = scpm_pkg::ST_FILL;
          scpm_pkg::KIND_READ:
            state_nxt = status.rd_ok ? scpm_pkg::ST_RD : scpm_pkg::ST_RESULT;
          default: state_nxt = scpm_pkg::ST_RESULT;
        endcase
      end
      scpm_pkg::ST_MUL:       state_nxt = scpm_pkg::ST_DIVQ;
      scpm_pkg::ST_DIVQ:      state_nxt = scpm_pkg::ST_DIVQ_WAIT;
      scpm_pkg::ST_DIVQ_WAIT: if (status.div_done) state_nxt = scpm_pkg::ST_DIVO;
      scpm_pkg::ST_DIVO:      state_nxt = scpm_pkg::ST_DIVO_WAIT;
      scpm_pkg::ST_DIVO_WAIT: if (status.div_done) state_nxt = scpm_pkg::ST_WALK;
      scpm_pkg::ST_WALK:      if (status.walk_last) state_nxt = scpm_pkg::ST_DRAIN;
      scpm_pkg::ST_DRAIN:     state_nxt = scpm_pkg::ST_RESULT;
      scpm_pkg::ST_FILL:      if (status.fill_last) state_nxt = scpm_pkg::ST_RESULT;
      scpm_pkg::ST_RD:        state_nxt = scpm_pkg::ST_RD_WAIT;
      scpm_pkg::ST_RD_WAIT:   state_nxt = scpm_pkg::ST_RESULT;
      scpm_pkg::ST_RESULT:    if (status.out_free) state_nxt = scpm_pkg::ST_IDLE;
      default:                state_nxt = scpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      scpm_pkg::ST_BOOT_FILL: begin
        cmd.fill = 1'b1;
        cmd.boot = 1'b1;
      end
      scpm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      scpm_pkg::ST_PREP: cmd.prep = 1'b1;
      scpm_pkg::ST_MUL:  cmd.mul  = 1'b1;
      scpm_pkg::ST_DIVQ: cmd.div_start = 1'b1;
      scpm_pkg::ST_DIVQ_WAIT: cmd.take_step = status.div_done;
      scpm_pkg::ST_DIVO: begin
        cmd.div_start = 1'b1;
        cmd.div_off   = 1'b1;
      end
      scpm_pkg::ST_DIVO_WAIT: begin
        cmd.div_off  = 1'b1;
        cmd.take_off = status.div_done;
      end
      scpm_pkg::ST_WALK:    cmd.step     = 1'b1;
      scpm_pkg::ST_FILL:    cmd.fill     = 1'b1;
      scpm_pkg::ST_RD:      cmd.rd_issue = 1'b1;
      scpm_pkg::ST_RD_WAIT: cmd.rd_take  = 1'b1;
      scpm_pkg::ST_RESULT:  cmd.push     = status.out_free;
      default: ;
    endcase
  end
endmodule

### src/segment_cut_profile_min.sv
// Top level of the segment cut profile block
// Keeps a signed 16-bit radius per column in a COLUMNS-deep memory and takes one request
// at a time. A read goes through set-up, a memory read and the result register. A cut
// spans its columns inside the work at one column per cycle after set-up: a multiply and
// two divisions on the shared bit-serial divider, then the walk, a drain step and the
// result, with the read of each column overlapped with the write-back of the one before;
// a vertical cut, or one that misses the work, needs no division. A reset request
// rewrites every column through the memory write port. After reset the block runs the
// same fill, with the reset radius, before it takes its first request; configuration
// writes are taken throughout. The result register lets the next request enter while
// the previous result still waits to be taken.
module segment_cut_profile_min #(
  parameter int COLUMNS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  scpm_in_if.sink                         in_ch,
  scpm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [scpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scpm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  scpm_pkg::cmd_t    cmd;
  scpm_pkg::status_t status;

  scpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  scpm_dp #(
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_kind           (in_ch.kind),
    .in_x_first        (in_ch.x_first),
    .in_y_first        (in_ch.y_first),
    .in_x_second       (in_ch.x_second),
    .in_y_second       (in_ch.y_second),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_column_radius (out_ch.column_radius),
    .out_read_valid    (out_ch.read_valid)
  );
endmodule

### test/scpm_profile_check.sv
// Passive profile tracker: follows both channels and the register port, checks each result
module scpm_profile_check #(
  parameter int COLUMNS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  scpm_in_if                              in_ch,
  scpm_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [scpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scpm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              replies_due,
  output int                              mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [15:0] column_radius;
    logic               read_valid;
  } reply_t;

  logic signed [15:0] profile_copy [COLUMNS];
  logic [10:0]        work_len;
  logic [14:0]        fill_radius;
  reply_t             replies_q [$];
  int                 bad_count;

  function automatic int columns_in_use();
    return (int'(work_len) > COLUMNS) ? COLUMNS : int'(work_len);
  endfunction

  function automatic void refill();
    for (int i = 0; i < COLUMNS; i++) profile_copy[i] = {1'b0, fill_radius};
  endfunction

  function automatic void cut_profile(input int x1, input int y1, input int x2, input int y2);
    int     xs, ys, xe, ye, lo, hi;
    longint dx, dy, h;
    if (x1 == x2) begin
      h = (y1 < y2) ? y1 : y2;
      if (x1 >= 0 && x1 < columns_in_use()) begin
        if (profile_copy[x1] > h) profile_copy[x1] = 16'(h);
      end
      return;
    end
    if (x1 < x2) begin
      xs = x1; ys = y1; xe = x2; ye = y2;
    end else begin
      xs = x2; ys = y2; xe = x1; ye = y1;
    end
    dx = xe - xs;
    dy = ye - ys;
    lo = (xs < 0) ? 0 : xs;
    hi = (xe < columns_in_use() - 1) ? xe : columns_in_use() - 1;
    for (int x = lo; x <= hi; x++) begin
      // exact height under the segment, truncated toward zero
      h = (longint'(ys) * dx + dy * longint'(x - xs)) / dx;
      if (profile_copy[x] > h) profile_copy[x] = 16'(h);
    end
  endfunction

  function automatic reply_t predict_reply(input logic [1:0] kind, input int x1, input int y1,
                                           input int x2, input int y2);
    reply_t r;
    r = '0;
    case (kind)
      scpm_pkg::KIND_CUT:   cut_profile(x1, y1, x2, y2);
      scpm_pkg::KIND_RESET: refill();
      scpm_pkg::KIND_READ: begin
        if (x1 >= 0 && x1 < columns_in_use()) begin
          r.column_radius = profile_copy[x1];
          r.read_valid    = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      work_len    = scpm_pkg::WORK_LENGTH_RST;
      fill_radius = scpm_pkg::MAX_RADIUS_RST;
      refill();
      replies_q.delete();
      bad_count = 0;
    end else begin
      // a result always belongs to an earlier request, so compare before predicting
      if (out_ch.valid && out_ch.ready) begin
        if (replies_q.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_LIMIT)
            $display("%0t: unexpected result: radius %0d valid %0b", $realtime,
                     out_ch.column_radius, out_ch.read_valid);
        end else begin
          want = replies_q.pop_front();
          if (out_ch.column_radius !== want.column_radius ||
              out_ch.read_valid !== want.read_valid) begin
            bad_count++;
            if (bad_count <= REPORT_LIMIT)
              $display("%0t: mismatch: expected radius %0d valid %0b, got radius %0d valid %0b",
                       $realtime, want.column_radius, want.read_valid,
                       out_ch.column_radius, out_ch.read_valid);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == scpm_pkg::REG_WORK_LENGTH) work_len = cfg_wdata[10:0];
        else if (cfg_index == scpm_pkg::REG_MAX_RADIUS) fill_radius = cfg_wdata[14:0];
      end
      if (in_ch.valid && in_ch.ready)
        replies_q.push_back(predict_reply(in_ch.kind, in_ch.x_first, in_ch.y_first,
                                          in_ch.x_second, in_ch.y_second));
    end
    replies_due <= replies_q.size();
    mismatches  <= bad_count;
  end

endmodule

### test/segment_cut_profile_min_tb.sv
// Testbench top: request and register stimulus for segment_cut_profile_min, watchdog, verdict
module segment_cut_profile_min_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS = 1024;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 32;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] x_first;
    logic signed [15:0] y_first;
    logic signed [15:0] x_second;
    logic signed [15:0] y_second;
  } request_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [scpm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [scpm_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                              replies_due;
  int                              mismatches;
  int                              send_idle_pct;
  int                              recv_idle_pct;
  int                              cur_work_len;
  int                              cur_max_radius;
  int                              quiet_cycles;

  scpm_in_if  req_ch ();
  scpm_out_if res_ch ();

  segment_cut_profile_min #(.COLUMNS(COLUMNS)) dut (
    .clk, .rst_n, .in_ch(req_ch), .out_ch(res_ch), .cfg_we, .cfg_index, .cfg_wdata
  );

  scpm_profile_check #(.COLUMNS(COLUMNS)) profile_watch (
    .clk, .rst_n, .in_ch(req_ch), .out_ch(res_ch), .cfg_we, .cfg_index, .cfg_wdata,
    .replies_due(replies_due), .mismatches(mismatches)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic logic signed [15:0] any16();
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       roll, x1, span, x2;
    roll = $urandom_range(99);
    r.kind     = scpm_pkg::KIND_CUT;
    r.x_first  = any16();
    r.y_first  = any16();
    r.x_second = any16();
    r.y_second = any16();
    if (roll < 42) begin
      // mostly short cuts near the work, heights around the current radius
      x1   = int'($urandom_range(cur_work_len + 15)) - 8;
      span = $urandom_range(99);
      if (span < 78) span = $urandom_range(24);
      else if (span < 95) span = $urandom_range(300, 25);
      else span = $urandom_range(1100, 301);
      x2 = $urandom_range(1) ? x1 + span : x1 - span;
      r.x_first  = 16'(x1);
      r.x_second = 16'(x2);
      if ($urandom_range(9) != 0) begin
        r.y_first  = 16'(int'($urandom_range(cur_max_radius + 64)) - 64);
        r.y_second = 16'(int'($urandom_range(cur_max_radius + 64)) - 64);
      end
    end else if (roll < 77) begin
      r.kind    = scpm_pkg::KIND_READ;
      r.x_first = 16'(int'($urandom_range(cur_work_len + 7)) - 4);
    end else if (roll < 82) begin
      r.kind = scpm_pkg::KIND_RESET;
    end else if (roll < 85) begin
      r.kind = KIND_SPARE;
    end else begin
      r.kind = 2'($urandom_range(3));
    end
    return r;
  endfunction

  // called just after a falling edge; returns just after the falling edge following acceptance
  task automatic send_request(input request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= r.kind;
    req_ch.x_first  <= r.x_first;
    req_ch.y_first  <= r.y_first;
    req_ch.x_second <= r.x_second;
    req_ch.y_second <= r.y_second;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic issue(input logic [1:0] kind, input int x1, input int y1,
                       input int x2, input int y2);
    request_t r;
    r.kind     = kind;
    r.x_first  = 16'(x1);
    r.y_first  = 16'(y1);
    r.x_second = 16'(x2);
    r.y_second = 16'(y2);
    send_request(r);
  endtask

  task automatic wait_for_replies();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (replies_due != 0);
  endtask

  task automatic reconfigure(input int work_len, input int radius);
    wait_for_replies();
    cfg_we    <= 1'b1;
    cfg_index <= scpm_pkg::REG_WORK_LENGTH;
    cfg_wdata <= scpm_pkg::CFG_DATA_W'(work_len);
    @(negedge clk);
    cfg_index <= scpm_pkg::REG_MAX_RADIUS;
    cfg_wdata <= scpm_pkg::CFG_DATA_W'(radius);
    @(negedge clk);
    cfg_we         <= 1'b0;
    cur_work_len   = work_len;
    cur_max_radius = radius;
  endtask

  task automatic random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(59) == 0) wait_for_replies();
      send_request(random_request());
    end
  endtask

  initial begin
    quiet_cycles = 0;
    do begin
      @(posedge clk);
      if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end while (quiet_cycles < STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.kind     = scpm_pkg::KIND_CUT;
    req_ch.x_first  = '0;
    req_ch.y_first  = '0;
    req_ch.x_second = '0;
    req_ch.y_second = '0;
    cfg_we          = 1'b0;
    cfg_index       = scpm_pkg::REG_WORK_LENGTH;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    send_idle_pct   = 14;
    recv_idle_pct   = 47;
    cur_work_len    = int'(scpm_pkg::WORK_LENGTH_RST);
    cur_max_radius  = int'(scpm_pkg::MAX_RADIUS_RST);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reads at and beyond both ends of the work
    issue(scpm_pkg::KIND_READ, 0, 0, 0, 0);
    issue(scpm_pkg::KIND_READ, 1023, 0, 0, 0);
    issue(scpm_pkg::KIND_READ, -1, 0, 0, 0);
    issue(scpm_pkg::KIND_READ, 1024, 0, 0, 0);
    issue(scpm_pkg::KIND_READ, 32767, 0, 0, 0);
    issue(scpm_pkg::KIND_READ, -32768, 0, 0, 0);
    // vertical cuts, inside and outside the work
    issue(scpm_pkg::KIND_CUT, 5, 300, 5, 200);
    issue(scpm_pkg::KIND_READ, 5, 0, 0, 0);
    issue(scpm_pkg::KIND_CUT, -3, -100, -3, -200);
    issue(scpm_pkg::KIND_CUT, 1023, -32768, 1023, 32767);
    issue(scpm_pkg::KIND_READ, 1023, 0, 0, 0);
    // sloped cuts in both orders; negative heights truncate toward zero
    issue(scpm_pkg::KIND_CUT, 10, 100, 20, -50);
    issue(scpm_pkg::KIND_READ, 15, 0, 0, 0);
    issue(scpm_pkg::KIND_CUT, 40, 500, 30, -7);
    issue(scpm_pkg::KIND_READ, 33, 0, 0, 0);
    issue(scpm_pkg::KIND_CUT, 100, -1, 103, -2);
    issue(scpm_pkg::KIND_READ, 102, 0, 0, 0);
    // full-range segment across the whole work
    issue(scpm_pkg::KIND_CUT, -32768, 32767, 32767, -32768);
    issue(scpm_pkg::KIND_READ, 0, 0, 0, 0);
    issue(scpm_pkg::KIND_READ, 512, 0, 0, 0);
    // segments that miss the work entirely, then the unused kind
    issue(scpm_pkg::KIND_CUT, 2000, 0, 3000, -5);
    issue(scpm_pkg::KIND_CUT, -50, -9, -10, -9);
    issue(KIND_SPARE, -1, -1, -1, -1);
    wait_for_replies();
    issue(scpm_pkg::KIND_RESET, 0, 0, 0, 0);
    issue(scpm_pkg::KIND_READ, 5, 0, 0, 0);

    reconfigure(1, 0);
    issue(scpm_pkg::KIND_RESET, 0, 0, 0, 0);
    random_items(40);

    reconfigure(1024, 32767);
    issue(scpm_pkg::KIND_RESET, 0, 0, 0, 0);
    random_items(120);

    send_idle_pct = 47;
    recv_idle_pct = 14;
    // no column in use: cuts change nothing and reads are out of range
    reconfigure(0, 500);
    issue(scpm_pkg::KIND_RESET, 0, 0, 0, 0);
    random_items(20);

    reconfigure(37, 2000);
    issue(scpm_pkg::KIND_RESET, 0, 0, 0, 0);
    random_items(110);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    reconfigure(1024, 1024);
    random_items(120);

    reconfigure($urandom_range(1024, 1), $urandom_range(32767));
    issue(scpm_pkg::KIND_RESET, 0, 0, 0, 0);
    random_items(100);

    wait_for_replies();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && replies_due == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
src/scpm_pkg.sv
src/scpm_in_if.sv
src/scpm_out_if.sv
src/scpm_ram.sv
src/scpm_div.sv
src/scpm_dp.sv
src/scpm_ctrl.sv
src/segment_cut_profile_min.sv
test/scpm_profile_check.sv
test/segment_cut_profile_min_tb.sv
